/* hdl/stack_calculator_unit_assert.svh */
// Assertion macros shared by the stack calculator modules.
`ifndef STACK_CALCULATOR_UNIT_ASSERT_SVH
`define STACK_CALCULATOR_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, masked while arst_n is low.
`define SCU_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("scu: same-cycle check failed");

// Next-cycle implication, sampled on clk, masked while arst_n is low.
`define SCU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("scu: next-cycle check failed");

`endif

/* hdl/scu_pkg.sv */
// Package with types, codes and constants of the stack calculator.
`timescale 1ns / 1ps

package scu_pkg;

	localparam int STACK_DEPTH_DEF = 64;
	localparam int DATA_W          = 32;
	localparam int POS_W           = 6;
	localparam int FILL_W          = 7;

	typedef enum logic [2:0] {
		CMD_PUSH     = 3'd0,
		CMD_POP      = 3'd1,
		CMD_PEEK_TOP = 3'd2,
		CMD_PEEK_BOT = 3'd3,
		CMD_ADD      = 3'd4,
		CMD_SUB      = 3'd5,
		CMD_MUL      = 3'd6,
		CMD_DIV      = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_FEW     = 3'd1,
		ST_RANGE   = 3'd2,
		ST_DIVZERO = 3'd3,
		ST_FULL    = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_RD_A,
		S_RD_B,
		S_EXEC,
		S_DIV_RUN,
		S_FINISH
	} state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic latch;
		logic rd_a;
		logic rd_b;
		logic cap_a;
		logic cap_b;
		logic alu_ld;
		logic div_start;
		logic div_ld;
		logic commit;
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic pre_err;
		logic is_push;
		logic is_arith;
		logic is_div;
		logic div_zero;
		logic div_done;
		logic out_free;
	} ctrl_sts_t;

endpackage

/* hdl/scu_div.sv */
// Iterative floor divider for signed 32-bit operands, one quotient bit per cycle.
`timescale 1ns / 1ps

module scu_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [scu_pkg::DATA_W-1:0]  dividend,
	input  logic [scu_pkg::DATA_W-1:0]  divisor,
	output logic                        done,
	output logic [scu_pkg::DATA_W-1:0]  quotient
);

	localparam int W  = scu_pkg::DATA_W;
	localparam int NW = $clog2(W);

	logic          busy_q;
	logic          done_q;
	logic [NW-1:0] count_q;
	logic          neg_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  rem_q;
	logic [W-1:0]  den_q;
	logic [W:0]    shifted;
	logic [W:0]    diff;

	// Trial subtract of the divisor from the shifted partial remainder
	assign shifted = {rem_q, quo_q[W-1]};
	assign diff    = shifted - {1'b0, den_q};

	// Sequence the iterations
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			count_q <= '0;
		end else if (start) begin
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
			count_q <= '0;
		end else if (busy_q) begin
			count_q <= count_q + NW'(1);
			if (count_q == NW'(W - 1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	// Load magnitudes, then shift in one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend[W-1] ? (~dividend + W'(1)) : dividend;
			den_q <= divisor[W-1] ? (~divisor + W'(1)) : divisor;
			rem_q <= '0;
			neg_q <= dividend[W-1] ^ divisor[W-1];
		end else if (busy_q) begin
			if (!diff[W]) begin
				rem_q <= diff[W-1:0];
			end else begin
				rem_q <= shifted[W-1:0];
			end
			quo_q <= {quo_q[W-2:0], !diff[W]};
		end
	end

	// Round toward minus infinity: a negative inexact quotient drops by one
	always_comb begin
		if (!neg_q) begin
			quotient = quo_q;
		end else if (rem_q != '0) begin
			quotient = ~quo_q;
		end else begin
			quotient = ~quo_q + W'(1);
		end
	end

	assign done = done_q;

endmodule

/* hdl/scu_dpath.sv */
// Datapath of the stack calculator: stack memory, pointer, operands, ALU and output register.
`timescale 1ns / 1ps

`include "stack_calculator_unit_assert.svh"

module scu_dpath #(
	parameter int DEPTH = scu_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  scu_pkg::ctrl_cmd_t                cmd,
	output scu_pkg::ctrl_sts_t                sts,
	input  logic [2:0]                        command,
	input  logic signed [scu_pkg::DATA_W-1:0] push_value,
	input  logic [scu_pkg::POS_W-1:0]         position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [scu_pkg::DATA_W-1:0] result_value,
	output logic [2:0]                        status,
	output logic [scu_pkg::FILL_W-1:0]        fill_count
);

	localparam int W   = scu_pkg::DATA_W;
	localparam int SPW = $clog2(DEPTH + 1);
	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = (SPW > scu_pkg::POS_W) ? SPW : scu_pkg::POS_W;

	scu_pkg::cmd_t            cmd_q;
	logic [W-1:0]             val_q;
	logic [scu_pkg::POS_W-1:0] pos_q;
	logic [SPW-1:0]           sp_q;
	logic [W-1:0]             mem [DEPTH];
	logic [W-1:0]             rdata_q;
	logic [W-1:0]             right_q;
	logic [W-1:0]             left_q;
	logic [W-1:0]             res_q;
	logic                     out_valid_q;
	logic [W-1:0]             result_value_q;
	scu_pkg::status_t         status_q;
	logic [scu_pkg::FILL_W-1:0] fill_count_q;

	logic [CW-1:0]            sp_ext;
	logic [CW-1:0]            pos_ext;
	logic [CW-1:0]            addr_a_full;
	logic [CW-1:0]            addr_b_full;
	logic [AW-1:0]            addr_a;
	logic [AW-1:0]            addr_b;
	logic                     is_push;
	logic                     is_arith;
	logic                     is_div;
	logic                     div_zero;
	logic                     div_done;
	logic [W-1:0]             quotient;
	scu_pkg::status_t         pre_code;
	scu_pkg::status_t         final_code;
	logic [SPW-1:0]           sp_nxt;
	logic [W-1:0]             res_out;
	logic                     mem_we;
	logic [AW-1:0]            waddr;
	logic [W-1:0]             wdata;
	logic                     out_free;

	// Hold the transaction fields while the command runs
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			cmd_q <= scu_pkg::cmd_t'(command);
			val_q <= push_value;
			pos_q <= position;
		end
	end

	// Decode the command
	assign is_push  = (cmd_q == scu_pkg::CMD_PUSH);
	assign is_div   = (cmd_q == scu_pkg::CMD_DIV);
	assign is_arith = (cmd_q == scu_pkg::CMD_ADD) || (cmd_q == scu_pkg::CMD_SUB) ||
		(cmd_q == scu_pkg::CMD_MUL) || (cmd_q == scu_pkg::CMD_DIV);
	assign div_zero = is_div && (right_q == '0);

	assign sp_ext  = CW'(sp_q);
	assign pos_ext = CW'(pos_q);

	// Check fill and index before touching the stack
	always_comb begin
		pre_code = scu_pkg::ST_OK;
		case (cmd_q)
			scu_pkg::CMD_PUSH: begin
				if (sp_q == SPW'(DEPTH)) pre_code = scu_pkg::ST_FULL;
			end
			scu_pkg::CMD_POP: begin
				if (sp_q == '0) pre_code = scu_pkg::ST_FEW;
			end
			scu_pkg::CMD_PEEK_TOP, scu_pkg::CMD_PEEK_BOT: begin
				if (pos_ext >= sp_ext) pre_code = scu_pkg::ST_RANGE;
			end
			default: begin
				if (sp_q < SPW'(2)) pre_code = scu_pkg::ST_FEW;
			end
		endcase
	end

	assign final_code = (pre_code != scu_pkg::ST_OK) ? pre_code :
		(div_zero ? scu_pkg::ST_DIVZERO : scu_pkg::ST_OK);

	// First read: top, indexed entry; second read: entry below the top
	always_comb begin
		case (cmd_q)
			scu_pkg::CMD_PEEK_TOP: addr_a_full = sp_ext - CW'(1) - pos_ext;
			scu_pkg::CMD_PEEK_BOT: addr_a_full = pos_ext;
			default:               addr_a_full = sp_ext - CW'(1);
		endcase
	end

	assign addr_b_full = sp_ext - CW'(2);
	assign addr_a      = addr_a_full[AW-1:0];
	assign addr_b      = addr_b_full[AW-1:0];

	// Stack memory read port, registered
	always_ff @(posedge clk) begin
		if (cmd.rd_a || cmd.rd_b) begin
			rdata_q <= mem[cmd.rd_b ? addr_b : addr_a];
		end
	end

	// Stack memory write port
	assign mem_we = cmd.commit && (pre_code == scu_pkg::ST_OK) &&
		(is_push || (is_arith && !div_zero));
	assign waddr  = is_push ? sp_q[AW-1:0] : addr_b;
	assign wdata  = is_push ? val_q : res_q;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[waddr] <= wdata;
		end
	end

	// Capture operands and compute the arithmetic result
	always_ff @(posedge clk) begin
		if (cmd.cap_a) right_q <= rdata_q;
		if (cmd.cap_b) left_q  <= rdata_q;
		if (cmd.alu_ld) begin
			case (cmd_q)
				scu_pkg::CMD_ADD: res_q <= left_q + right_q;
				scu_pkg::CMD_SUB: res_q <= left_q - right_q;
				default:          res_q <= left_q * right_q;
			endcase
		end else if (cmd.div_ld) begin
			res_q <= quotient;
		end
	end

	scu_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (left_q),
		.divisor  (right_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Next stack pointer
	always_comb begin
		sp_nxt = sp_q;
		if (pre_code == scu_pkg::ST_OK) begin
			case (cmd_q)
				scu_pkg::CMD_PUSH:                            sp_nxt = sp_q + SPW'(1);
				scu_pkg::CMD_POP:                             sp_nxt = sp_q - SPW'(1);
				scu_pkg::CMD_PEEK_TOP, scu_pkg::CMD_PEEK_BOT: sp_nxt = sp_q;
				default: sp_nxt = div_zero ? (sp_q - SPW'(2)) : (sp_q - SPW'(1));
			endcase
		end
	end

	// Select the result, forced to zero on any error
	always_comb begin
		case (cmd_q)
			scu_pkg::CMD_PUSH:                                              res_out = '0;
			scu_pkg::CMD_POP, scu_pkg::CMD_PEEK_TOP, scu_pkg::CMD_PEEK_BOT: res_out = right_q;
			default:                                                        res_out = res_q;
		endcase
		if (final_code != scu_pkg::ST_OK) res_out = '0;
	end

	assign out_free = !out_valid_q || !out_stall;

	// Advance the stack pointer on commit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q <= '0;
		end else if (cmd.commit) begin
			sp_q <= sp_nxt;
		end
	end

	// Output register: set on commit, drop when the transaction is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			result_value_q <= res_out;
			status_q       <= final_code;
			fill_count_q   <= scu_pkg::FILL_W'(sp_nxt);
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign status       = status_q;
	assign fill_count   = fill_count_q;

	assign sts.pre_err  = (pre_code != scu_pkg::ST_OK);
	assign sts.is_push  = is_push;
	assign sts.is_arith = is_arith;
	assign sts.is_div   = is_div;
	assign sts.div_zero = div_zero;
	assign sts.div_done = div_done;
	assign sts.out_free = out_free;

	`SCU_ASSERT_IMPL(a_sp_bound, 1'b1, sp_q <= SPW'(DEPTH))
	`SCU_ASSERT_IMPL(a_err_zero, out_valid_q && (status_q != scu_pkg::ST_OK), result_value_q == '0)
	`SCU_ASSERT_NEXT(a_push_grow, cmd.commit && is_push && (pre_code == scu_pkg::ST_OK), sp_q == $past(sp_q) + SPW'(1))

endmodule

/* hdl/scu_ctrl.sv */
// Controller state machine of the stack calculator.
`timescale 1ns / 1ps

`include "stack_calculator_unit_assert.svh"

module scu_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  scu_pkg::ctrl_sts_t sts,
	output scu_pkg::ctrl_cmd_t cmd
);

	scu_pkg::state_t state_q;
	scu_pkg::state_t state_nxt;

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scu_pkg::S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Next state and datapath commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			scu_pkg::S_IDLE: begin
				if (in_valid) begin
					cmd.latch = 1'b1;
					state_nxt = scu_pkg::S_CHECK;
				end
			end
			scu_pkg::S_CHECK: begin
				if (sts.pre_err || sts.is_push) begin
					state_nxt = scu_pkg::S_FINISH;
				end else begin
					cmd.rd_a  = 1'b1;
					state_nxt = scu_pkg::S_RD_A;
				end
			end
			scu_pkg::S_RD_A: begin
				cmd.cap_a = 1'b1;
				if (sts.is_arith) begin
					cmd.rd_b  = 1'b1;
					state_nxt = scu_pkg::S_RD_B;
				end else begin
					state_nxt = scu_pkg::S_FINISH;
				end
			end
			scu_pkg::S_RD_B: begin
				cmd.cap_b = 1'b1;
				state_nxt = scu_pkg::S_EXEC;
			end
			scu_pkg::S_EXEC: begin
				if (!sts.is_div) begin
					cmd.alu_ld = 1'b1;
					state_nxt  = scu_pkg::S_FINISH;
				end else if (sts.div_zero) begin
					state_nxt = scu_pkg::S_FINISH;
				end else begin
					cmd.div_start = 1'b1;
					state_nxt     = scu_pkg::S_DIV_RUN;
				end
			end
			scu_pkg::S_DIV_RUN: begin
				if (sts.div_done) begin
					cmd.div_ld = 1'b1;
					state_nxt  = scu_pkg::S_FINISH;
				end
			end
			scu_pkg::S_FINISH: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_nxt  = scu_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = scu_pkg::S_IDLE;
			end
		endcase
	end

	assign in_stall = (state_q != scu_pkg::S_IDLE);

	`SCU_ASSERT_NEXT(a_accept_check, in_valid && !in_stall, state_q == scu_pkg::S_CHECK)
	`SCU_ASSERT_IMPL(a_rdb_arith, state_q == scu_pkg::S_RD_B, sts.is_arith)
	`SCU_ASSERT_IMPL(a_div_done_state, sts.div_done, state_q == scu_pkg::S_DIV_RUN)

endmodule

/* hdl/stack_calculator_unit.sv */
// Path from accept to result: push and stack or index errors go from check to finish; pop
// and peek add one stack read; add, subtract, multiply and divide by zero read both operands
// through the single read port and execute; divide also runs the 32-iteration divider.
// One command at a time; the next is taken once the last commits, held off by out_stall.
// Reset (arst_n low) empties the stack at once; memory contents are not cleared.
// Top level of the stack calculator: controller, datapath and stack memory.
`timescale 1ns / 1ps

module stack_calculator_unit #(
	parameter int STACK_DEPTH = scu_pkg::STACK_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [2:0]                        command,
	input  logic signed [scu_pkg::DATA_W-1:0] push_value,
	input  logic [scu_pkg::POS_W-1:0]         position,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [scu_pkg::DATA_W-1:0] result_value,
	output logic [2:0]                        status,
	output logic [scu_pkg::FILL_W-1:0]        fill_count
);

	scu_pkg::ctrl_cmd_t cmd;
	scu_pkg::ctrl_sts_t sts;

	scu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	scu_dpath #(
		.DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.command      (command),
		.push_value   (push_value),
		.position     (position),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_value (result_value),
		.status       (status),
		.fill_count   (fill_count)
	);

endmodule

/* tb/sv/stack_calculator_unit_tb.sv */
// Self-checking testbench for the stack calculator unit with a scoreboard class.
`timescale 1ns / 1ps

module stack_calculator_unit_tb;

	localparam int DEPTH      = scu_pkg::STACK_DEPTH_DEF;
	localparam int DATA_W     = scu_pkg::DATA_W;
	localparam int POS_W      = scu_pkg::POS_W;
	localparam int FILL_W     = scu_pkg::FILL_W;
	localparam int IDLE_LIMIT = 4000;
	localparam int END_DRAIN  = 60;

	typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		scu_pkg::status_t         code;
		logic [FILL_W-1:0]        fill;
	} stack_result_t;

	// Scoreboard: mirrors the stack and holds the results still owed by the unit
	class stack_scoreboard;
		logic signed [DATA_W-1:0] entries [DEPTH];
		int                       fill_level;
		stack_result_t            pending [$];
		int                       error_count;

		function new();
			fill_level  = 0;
			error_count = 0;
		endfunction

		task report(string what);
			$display("%0t ns mismatch: %s", $time, what);
			error_count++;
		endtask

		// Apply one accepted command to the mirror and queue the result it owes
		function void note_command(scu_pkg::cmd_t cmd, logic signed [DATA_W-1:0] value,
				logic [POS_W-1:0] pos);
			stack_result_t            r;
			logic signed [DATA_W-1:0] lhs;
			logic signed [DATA_W-1:0] rhs;
			longint                   num;
			longint                   den;
			longint                   quo;
			r.value = '0;
			r.code  = scu_pkg::ST_OK;
			case (cmd)
				scu_pkg::CMD_PUSH: begin
					if (fill_level >= DEPTH) begin
						r.code = scu_pkg::ST_FULL;
					end else begin
						entries[fill_level] = value;
						fill_level++;
					end
				end
				scu_pkg::CMD_POP: begin
					if (fill_level == 0) begin
						r.code = scu_pkg::ST_FEW;
					end else begin
						fill_level--;
						r.value = entries[fill_level];
					end
				end
				scu_pkg::CMD_PEEK_TOP, scu_pkg::CMD_PEEK_BOT: begin
					if (pos >= fill_level)
						r.code = scu_pkg::ST_RANGE;
					else if (cmd == scu_pkg::CMD_PEEK_TOP)
						r.value = entries[fill_level - 1 - pos];
					else
						r.value = entries[pos];
				end
				default: begin
					if (fill_level < 2) begin
						r.code = scu_pkg::ST_FEW;
					end else begin
						rhs = entries[fill_level - 1];
						lhs = entries[fill_level - 2];
						fill_level -= 2;
						case (cmd)
							scu_pkg::CMD_ADD: r.value = lhs + rhs;
							scu_pkg::CMD_SUB: r.value = lhs - rhs;
							scu_pkg::CMD_MUL: r.value = lhs * rhs;
							default: begin
								if (rhs == 0) begin
									r.code = scu_pkg::ST_DIVZERO;
								end else begin
									// floor the quotient; min / -1 wraps back to min
									num = lhs;
									den = rhs;
									quo = num / den;
									if ((num % den) != 0 && ((num < 0) != (den < 0)))
										quo--;
									r.value = quo[DATA_W-1:0];
								end
							end
						endcase
						if (r.code == scu_pkg::ST_OK) begin
							entries[fill_level] = r.value;
							fill_level++;
						end
					end
				end
			endcase
			if (r.code != scu_pkg::ST_OK)
				r.value = '0;
			r.fill = fill_level[FILL_W-1:0];
			pending.push_back(r);
		endfunction

		// Compare one accepted result with the oldest pending one
		task check_result(logic signed [DATA_W-1:0] value, logic [2:0] code,
				logic [FILL_W-1:0] fill);
			stack_result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result value=%0d status=%0d fill=%0d",
					value, code, fill));
				return;
			end
			want = pending.pop_front();
			if (value !== want.value)
				report($sformatf("result_value %0d, expected %0d", value, want.value));
			if (code !== want.code)
				report($sformatf("status %0d, expected %s", code, want.code.name()));
			if (fill !== want.fill)
				report($sformatf("fill_count %0d, expected %0d", fill, want.fill));
		endtask
	endclass

	logic                     clk;
	logic                     arst_n;
	logic                     in_valid;
	logic                     in_stall;
	logic [2:0]               command;
	logic signed [DATA_W-1:0] push_value;
	logic [POS_W-1:0]         position;
	logic                     out_valid;
	logic                     out_stall;
	logic signed [DATA_W-1:0] result_value;
	logic [2:0]               status;
	logic [FILL_W-1:0]        fill_count;

	stack_scoreboard sb = new();
	int              idle_cycles;

	stack_calculator_unit #(
		.STACK_DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.push_value(push_value),
		.position(position),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.result_value(result_value),
		.status(status),
		.fill_count(fill_count)
	);

	// Generate the clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Present one command and hold it until the unit accepts it
	task automatic send_command(scu_pkg::cmd_t cmd, logic signed [DATA_W-1:0] value,
			logic [POS_W-1:0] pos);
		in_valid   <= 1'b1;
		command    <= cmd;
		push_value <= value;
		position   <= pos;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_command(cmd, value, pos);
	endtask

	task automatic idle_gap(int cycles);
		in_valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return 32'sh8000_0000;
			1:       return 32'sh7fff_ffff;
			2:       return '0;
			3:       return -1;
			4, 5, 6: return int'($urandom_range(0, 16)) - 8;
			default: return $urandom;
		endcase
	endfunction

	// Mostly valid indexes, with a share anywhere in the field
	function automatic logic [POS_W-1:0] pick_position();
		if (sb.fill_level > 0 && $urandom_range(0, 3) != 0)
			return POS_W'($urandom_range(0, sb.fill_level - 1));
		return POS_W'($urandom_range(0, (1 << POS_W) - 1));
	endfunction

	function automatic scu_pkg::cmd_t pick_command(mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		case (mix)
			MIX_FILL: begin
				if (r < 88)      return scu_pkg::CMD_PUSH;
				else if (r < 94) return scu_pkg::CMD_PEEK_TOP;
				else             return scu_pkg::CMD_PEEK_BOT;
			end
			MIX_DRAIN: begin
				if (r < 10)      return scu_pkg::CMD_PUSH;
				else if (r < 30) return scu_pkg::CMD_POP;
				else if (r < 40) return r[0] ? scu_pkg::CMD_PEEK_TOP : scu_pkg::CMD_PEEK_BOT;
				else             return scu_pkg::cmd_t'(scu_pkg::CMD_ADD + $urandom_range(0, 3));
			end
			default: return scu_pkg::cmd_t'($urandom_range(0, 7));
		endcase
	endfunction

	// Edge cases: empty stack, overflow wraps, floor division, divide by zero
	task automatic run_directed();
		send_command(scu_pkg::CMD_POP,      0, 0);
		send_command(scu_pkg::CMD_PEEK_TOP, 0, 0);
		send_command(scu_pkg::CMD_PEEK_BOT, 0, 63);
		send_command(scu_pkg::CMD_ADD,      0, 0);
		send_command(scu_pkg::CMD_PUSH,     32'sh7fff_ffff, 0);
		send_command(scu_pkg::CMD_SUB,      0, 0);
		send_command(scu_pkg::CMD_PUSH,     1, 0);
		send_command(scu_pkg::CMD_ADD,      0, 0);
		send_command(scu_pkg::CMD_PUSH,     -1, 0);
		send_command(scu_pkg::CMD_DIV,      0, 0);
		send_command(scu_pkg::CMD_PUSH,     0, 0);
		send_command(scu_pkg::CMD_DIV,      0, 0);
		send_command(scu_pkg::CMD_PUSH,     -7, 0);
		send_command(scu_pkg::CMD_PUSH,     2, 0);
		send_command(scu_pkg::CMD_DIV,      0, 0);
		send_command(scu_pkg::CMD_PUSH,     -6, 0);
		send_command(scu_pkg::CMD_PUSH,     3, 0);
		send_command(scu_pkg::CMD_DIV,      0, 0);
		send_command(scu_pkg::CMD_PUSH,     32'sh8000_0000, 0);
		send_command(scu_pkg::CMD_MUL,      0, 0);
		send_command(scu_pkg::CMD_PEEK_TOP, 0, 1);
		send_command(scu_pkg::CMD_PEEK_BOT, 0, 2);
		send_command(scu_pkg::CMD_SUB,      0, 0);
		send_command(scu_pkg::CMD_POP,      0, 0);
		send_command(scu_pkg::CMD_POP,      0, 0);
	endtask

	// Random bursts; the command mix shifts between filling, draining and even
	task automatic run_random(int total);
		int   sent;
		int   burst;
		int   mode_left;
		mix_t mix;
		sent      = 0;
		mode_left = 0;
		mix       = MIX_EVEN;
		while (sent < total) begin
			burst = $urandom_range(1, 24);
			repeat (burst) begin
				if (mode_left == 0) begin
					mix       = mix_t'($urandom_range(0, 2));
					mode_left = (mix == MIX_FILL) ? $urandom_range(4, 10) : $urandom_range(30, 90);
				end
				// a fill phase only counts down once the stack is full
				if (mix != MIX_FILL || sb.fill_level == DEPTH)
					mode_left--;
				send_command(pick_command(mix), pick_value(), pick_position());
				sent++;
			end
			if ($urandom_range(0, 3) != 0)
				idle_gap($urandom_range(1, 40));
		end
	endtask

	// Drive reset and stimulus, then wait for the unit to drain
	initial begin
		arst_n     <= 1'b0;
		in_valid   <= 1'b0;
		command    <= scu_pkg::CMD_PUSH;
		push_value <= '0;
		position   <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		run_random(600);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (END_DRAIN) @(posedge clk);
		if (sb.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Stall the result side in runs: open, random, mostly stalled, periodic
	initial begin
		int mode;
		int run_len;
		int tick;
		out_stall <= 1'b0;
		tick = 0;
		forever begin
			mode    = $urandom_range(0, 3);
			run_len = $urandom_range(20, 200);
			repeat (run_len) begin
				@(posedge clk);
				tick++;
				case (mode)
					0:       out_stall <= 1'b0;
					1:       out_stall <= 1'($urandom_range(0, 1));
					2:       out_stall <= ($urandom_range(0, 7) != 0);
					default: out_stall <= ((tick % 16) < 10);
				endcase
			end
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_result(result_value, status, fill_count);
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

endmodule
